### rtl/rbfz_pkg.sv
package rbfz_pkg;

    // operation codes of a request
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_INVERT = 2'd2;

    // value width inside the chain, wide enough for the largest universe plus one
    localparam int VAL_W = 17;

    // what one cell hands to its right neighbor
    typedef struct packed {
        logic             vld;
        logic [1:0]       op;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic             found;
        logic [VAL_W-1:0] first;
    } t_link;

endpackage

### rtl/range_bitmap_first_zero.sv
// range membership bitmap with smallest-missing-value report
//
// input channel: i_valid / o_stall carry one request item (i_req_type,
// i_range_low, i_range_high). an item is taken at a rising edge with
// i_valid high and o_stall low. req_type 0 adds the inclusive range,
// 1 removes it, 2 inverts it, 3 does nothing. low of zero acts as one,
// high past the universe acts as the universe, a reversed range does nothing
// output channel: o_valid / i_stall carry one result item per request,
// o_first_missing, the smallest absent value or UNIVERSE+1 (low 11 bits)
// the bitmap sits in a chain of NUM_WORDS cells, one word each. a request
// walks the chain one cell per cycle, each cell updates its word and folds
// its lowest zero into the running answer
// o_valid rises once the request has passed every cell and the result register;
// only one item is in flight, from acceptance until its result is handed off,
// so a receiver stall also holds off the next item; the next item
// is taken in the cycle after the result has been handed off
// reset: synchronous, active low, empties the set and drops any result
// stall: while i_stall holds, the result stays put and o_stall stays high
module range_bitmap_first_zero
    import rbfz_pkg::*;
#(
    parameter int UNIVERSE  = 1024,
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [10:0] i_range_low,
    input  logic [10:0] i_range_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_first_missing
);

    localparam int NUM_WORDS = (UNIVERSE + WORD_BITS - 1) / WORD_BITS;
    localparam logic [VAL_W-1:0] U_VAL = VAL_W'(UNIVERSE);

    logic              r_busy;
    logic              r_ovld;
    logic [10:0]       r_first;
    logic              w_in_acc;
    logic              w_out_acc;
    logic [VAL_W-1:0]  w_lo;
    logic [VAL_W-1:0]  w_hi;
    logic [NUM_WORDS:0] w_vld;
    t_link             w_link [NUM_WORDS+1];

    assign w_in_acc  = i_valid && !r_busy;
    assign w_out_acc = r_ovld && !i_stall;

    // clamp the range into the universe; a low past it gives an empty range
    always_comb begin
        w_lo = VAL_W'(i_range_low);
        w_hi = VAL_W'(i_range_high);
        if (w_lo == '0) begin
            w_lo = VAL_W'(1);
        end else if (w_lo > U_VAL) begin
            w_lo = U_VAL + VAL_W'(1);
        end
        if (w_hi > U_VAL) begin
            w_hi = U_VAL;
        end
    end

    // launch into the head of the chain in the cycle of acceptance
    always_comb begin
        w_link[0].vld   = w_in_acc;
        w_link[0].op    = i_req_type;
        w_link[0].lo    = w_lo;
        w_link[0].hi    = w_hi;
        w_link[0].found = 1'b0;
        w_link[0].first = '0;
    end

    genvar k;
    generate
        for (k = 0; k < NUM_WORDS; k++) begin : g_cell
            rbfz_cell #(
                .IDX       (k),
                .WORD_BITS (WORD_BITS),
                .UNIVERSE  (UNIVERSE)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_link  (w_link[k]),
                .o_link  (w_link[k+1])
            );
        end
        for (k = 0; k <= NUM_WORDS; k++) begin : g_vld
            assign w_vld[k] = w_link[k].vld;
        end
    endgenerate

    // busy from acceptance until the result is handed off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_out_acc) begin
                r_busy <= 1'b0;
            end
            if (w_link[NUM_WORDS].vld) begin
                r_ovld <= 1'b1;
            end else if (w_out_acc) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // no zero anywhere means the whole universe is present
    always_ff @(posedge i_clk) begin
        if (w_link[NUM_WORDS].vld) begin
            if (w_link[NUM_WORDS].found) begin
                r_first <= w_link[NUM_WORDS].first[10:0];
            end else begin
                r_first <= 11'(UNIVERSE + 1);
            end
        end
    end

    assign o_stall         = r_busy;
    assign o_valid         = r_ovld;
    assign o_first_missing = r_first;

    // at most one request walks the chain
    a_one_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one request in the cell chain");

    // a request never reaches the end while a result still waits
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[NUM_WORDS].vld |-> !r_ovld)
        else $error("result register overrun");

    // a pending result keeps the input side closed
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> r_busy)
        else $error("input open while a result is pending");

    // an accepted request keeps the block busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_busy)
        else $error("not busy after acceptance");

endmodule

### rtl/rbfz_cell.sv
module rbfz_cell
    import rbfz_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int WORD_BITS = 64,
    parameter int UNIVERSE  = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_link i_link,
    output t_link o_link
);

    localparam int PW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_live;
    logic                 w_hit;
    logic [PW-1:0]        w_pos;
    t_link                r_link;
    t_link                n_link;

    // range mask and live bits of this word
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_live[b] = ((IDX * WORD_BITS + b) < UNIVERSE);
            w_mask[b] = w_live[b]
                && (VAL_W'(IDX * WORD_BITS + b + 1) >= i_link.lo)
                && (VAL_W'(IDX * WORD_BITS + b + 1) <= i_link.hi);
        end
    end

    always_comb begin
        case (i_link.op)
            OP_ADD:    n_word = r_word | w_mask;
            OP_REMOVE: n_word = r_word & ~w_mask;
            OP_INVERT: n_word = r_word ^ w_mask;
            default:   n_word = r_word;
        endcase
    end

    // lowest live zero of the updated word
    always_comb begin
        w_hit = 1'b0;
        w_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_live[b] && !n_word[b]) begin
                w_hit = 1'b1;
                w_pos = PW'(b);
            end
        end
    end

    always_comb begin
        n_link = i_link;
        if (!i_link.found && w_hit) begin
            n_link.found = 1'b1;
            n_link.first = VAL_W'(IDX * WORD_BITS + 1) + VAL_W'(w_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        r_link.op    <= n_link.op;
        r_link.lo    <= n_link.lo;
        r_link.hi    <= n_link.hi;
        r_link.found <= n_link.found;
        r_link.first <= n_link.first;
        if (!i_rst_n) begin
            r_word     <= '0;
            r_link.vld <= 1'b0;
        end else begin
            r_link.vld <= i_link.vld;
            if (i_link.vld) begin
                r_word <= n_word;
            end
        end
    end

    assign o_link = r_link;

endmodule
